@@ hdl/spirf_pkg.sv @@
// ============================================================================
// spirf_pkg: shared types and constants of the SPI register file
// Command codes, register addresses, field widths and the request bundle
// that the control logic sends to the register storage.
// ============================================================================
package spirf_pkg;

  // Field widths
  localparam int unsigned AddrW    = 8;
  localparam int unsigned DataW    = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned DelayW   = 20;
  localparam int unsigned RegCount = 1 << AddrW;

  // Input command codes
  localparam logic [CmdW-1:0] CMD_BYTE = 2'd0;
  localparam logic [CmdW-1:0] CMD_END  = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK = 2'd2;

  // Header decode
  localparam logic [DataW-1:0] HDR_WRITE_BIT = 8'h80;
  localparam logic [DataW-1:0] HDR_ADDR_MASK = 8'h7F;

  // Register addresses and values
  localparam logic [AddrW-1:0] ADDR_OP_MODE   = 8'h01;
  localparam logic [AddrW-1:0] ADDR_PA_CONFIG = 8'h09;
  localparam logic [AddrW-1:0] ADDR_IRQ_FLAGS = 8'h12;
  localparam logic [AddrW-1:0] ADDR_VERSION   = 8'h42;

  localparam logic [DataW-1:0] TX_MODE_VALUE  = 8'h83;
  localparam logic [DataW-1:0] TX_DONE_FLAG   = 8'h08;
  localparam logic [DataW-1:0] VERSION_RST    = 8'h12;
  localparam logic [DataW-1:0] OP_MODE_RST    = 8'h80;
  localparam logic [DataW-1:0] PA_CONFIG_RST  = 8'h4F;

  localparam logic [DelayW-1:0] DELAY_RST = 20'd500000;

  // One write port and one read port of the register storage
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } rf_req_t;

  // Value a register holds after reset
  function automatic logic [DataW-1:0] rf_reset_value(input logic [AddrW-1:0] addr);
    logic [DataW-1:0] val;
    unique case (addr)
      ADDR_VERSION:   val = VERSION_RST;
      ADDR_OP_MODE:   val = OP_MODE_RST;
      ADDR_PA_CONFIG: val = PA_CONFIG_RST;
      default:        val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/spirf_regfile.sv @@
// ============================================================================
// spirf_regfile: 256-byte register storage
// One write and one registered read per cycle. A per-entry valid bit makes
// an entry that was never written read back as its reset value.
// ============================================================================
module spirf_regfile (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spirf_pkg::rf_req_t                  req_i,
  output logic [spirf_pkg::DataW-1:0]         rd_data_o
);

  logic [spirf_pkg::DataW-1:0] mem_q [spirf_pkg::RegCount];
  logic [spirf_pkg::RegCount-1:0] vld_q;
  logic [spirf_pkg::DataW-1:0] rdata_q;
  logic [spirf_pkg::DataW-1:0] rdflt_q;
  logic                        rvld_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
      rdflt_q <= spirf_pkg::rf_reset_value(req_i.rd_addr);
    end
  end

  // Track written entries; reset restores every entry at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : rdflt_q;

endmodule

@@ hdl/spi_register_file_with_tx_done.sv @@
// ============================================================================
// spi_register_file_with_tx_done: SPI slave register bank with tx-done irq
// Decodes SPI bytes, transaction ends and time ticks against a 256-byte
// register file with auto-incrementing address and a one-shot countdown.
// ============================================================================
// Pipeline: an accepted word passes through the result stage and then the
// output register, and waits in the result stage while the output stalls.
// Throughput: one word per cycle unless the output stalls; one write port
// and one read port of the register file serve each word in one pass.
// Reset: all control state takes its reset value at once; register contents
// return to their reset values through per-entry valid bits, no clearing pass.
module spi_register_file_with_tx_done (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spirf_pkg::DelayW-1:0]       cfg_data_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [spirf_pkg::CmdW-1:0]         command_i,
  input  logic [spirf_pkg::DataW-1:0]        data_byte_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [spirf_pkg::DataW-1:0]        read_data_o,
  output logic                               irq_line_o
);

  // Control state
  logic [spirf_pkg::DelayW-1:0] delay_cfg_q;
  logic [spirf_pkg::AddrW-1:0]  ptr_q, ptr_d;
  logic                         wr_xfer_q, wr_xfer_d;
  logic                         await_hdr_q, await_hdr_d;
  logic                         pending_q, pending_d;
  logic                         irq_q, irq_d;
  logic [spirf_pkg::DelayW-1:0] delay_cnt_q, delay_cnt_d;

  // Result stage after the storage read, and output register
  logic                         s1_valid_q;
  logic                         s1_is_read_q;
  logic                         s1_irq_q;
  logic                         out_valid_q;
  logic [spirf_pkg::DataW-1:0]  out_data_q;
  logic                         out_irq_q;

  logic                         in_fire;
  logic                         s1_adv;
  spirf_pkg::rf_req_t           rf_req;
  logic                         is_read;
  logic [spirf_pkg::DataW-1:0]  rf_rdata;

  // Handshake: the result stage moves on when the output is free or taken
  assign s1_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Decode one word against the current state
  always_comb begin
    ptr_d       = ptr_q;
    wr_xfer_d   = wr_xfer_q;
    await_hdr_d = await_hdr_q;
    pending_d   = pending_q;
    irq_d       = irq_q;
    delay_cnt_d = delay_cnt_q;
    is_read     = 1'b0;
    rf_req      = '0;
    rf_req.rd_addr = ptr_q;
    unique case (command_i)
      spirf_pkg::CMD_BYTE: begin
        if (await_hdr_q) begin
          await_hdr_d = 1'b0;
          wr_xfer_d   = (data_byte_i & spirf_pkg::HDR_WRITE_BIT) != '0;
          ptr_d       = data_byte_i & spirf_pkg::HDR_ADDR_MASK;
        end else begin
          if (wr_xfer_q) begin
            rf_req.wr_en   = 1'b1;
            rf_req.wr_addr = ptr_q;
            rf_req.wr_data = data_byte_i;
            if (ptr_q == spirf_pkg::ADDR_OP_MODE &&
                data_byte_i == spirf_pkg::TX_MODE_VALUE && !pending_q) begin
              pending_d   = 1'b1;
              delay_cnt_d = delay_cfg_q;
            end
          end else begin
            is_read      = 1'b1;
            rf_req.rd_en = 1'b1;
          end
          ptr_d = ptr_q + 8'd1;
        end
      end
      spirf_pkg::CMD_END: begin
        await_hdr_d = 1'b1;
        if (irq_q) begin
          irq_d          = 1'b0;
          rf_req.wr_en   = 1'b1;
          rf_req.wr_addr = spirf_pkg::ADDR_IRQ_FLAGS;
          rf_req.wr_data = '0;
        end
      end
      spirf_pkg::CMD_TICK: begin
        if (pending_q) begin
          // a count of zero or one expires on this tick
          if (delay_cnt_q[spirf_pkg::DelayW-1:1] == '0) begin
            delay_cnt_d    = '0;
            pending_d      = 1'b0;
            irq_d          = 1'b1;
            rf_req.wr_en   = 1'b1;
            rf_req.wr_addr = spirf_pkg::ADDR_IRQ_FLAGS;
            rf_req.wr_data = spirf_pkg::TX_DONE_FLAG;
          end else begin
            delay_cnt_d = delay_cnt_q - 20'd1;
          end
        end
      end
      default: begin
      end
    endcase
    // drop the storage access unless the word is taken
    if (!in_fire) begin
      rf_req.wr_en = 1'b0;
      rf_req.rd_en = 1'b0;
    end
  end

  spirf_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rf_req),
    .rd_data_o (rf_rdata)
  );

  // Update control state on an accepted word; load the delay setting on a config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cfg_q <= spirf_pkg::DELAY_RST;
      ptr_q       <= '0;
      wr_xfer_q   <= 1'b0;
      await_hdr_q <= 1'b1;
      pending_q   <= 1'b0;
      irq_q       <= 1'b0;
      delay_cnt_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        delay_cfg_q <= cfg_data_i;
      end
      if (in_fire) begin
        ptr_q       <= ptr_d;
        wr_xfer_q   <= wr_xfer_d;
        await_hdr_q <= await_hdr_d;
        pending_q   <= pending_d;
        irq_q       <= irq_d;
        delay_cnt_q <= delay_cnt_d;
      end
    end
  end

  // Advance the result stage and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload of the result stage and output register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_is_read_q <= is_read;
      s1_irq_q     <= irq_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= s1_is_read_q ? rf_rdata : '0;
      out_irq_q  <= s1_irq_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign irq_line_o  = out_irq_q;

  // Checks
  a_stall_needs_full_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled while the result stage is empty");

  a_fire_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted word did not reach the result stage");

  a_idle_counter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> delay_cnt_q == '0)
    else $error("delay counter nonzero with no transmit pending");

endmodule
